// ===== src/lvm_pkg.sv =====
// Shared types, constants and rounding helper for the look-at view matrix unit.
// Used by lvm_front, lvm_norm, lvm_back and lookat_view_matrix_unit.
package lvm_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int VW = 50;
    localparam int UW = 18;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [32:0] diff_x;
        logic signed [32:0] diff_y;
        logic signed [32:0] diff_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } lvm_item_t;

    typedef struct packed {
        logic              start;
        logic signed [VW-1:0] v0;
        logic signed [VW-1:0] v1;
        logic signed [VW-1:0] v2;
    } lvm_norm_req_t;

    typedef struct packed {
        logic              done;
        logic              zero;
        logic signed [UW-1:0] o0;
        logic signed [UW-1:0] o1;
        logic signed [UW-1:0] o2;
    } lvm_norm_rsp_t;

    function automatic logic signed [31:0] rnd_sat(input logic signed [67:0] x,
                                                   input logic negate);
        logic [67:0] mag;
        logic [67:0] r;
        logic signed [68:0] v;
        logic signed [68:0] smax;
        logic signed [68:0] smin;
        smax = 69'sd2147483647;
        smin = -69'sd2147483648;
        mag = x[67] ? 68'(-x) : 68'(x);
        r = (mag + 68'd32768) >> 16;
        v = (x[67] ^ negate) ? -$signed({1'b0, r}) : $signed({1'b0, r});
        if (v > smax) begin
            return 32'sh7fff_ffff;
        end else if (v < smin) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== src/lvm_front.sv =====
// Input side: takes beats, forms eye minus target, and queues the items.
// Depends on lvm_pkg.
module lvm_front import lvm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_world_up_x,
    input  logic signed [31:0] s_world_up_y,
    input  logic signed [31:0] s_world_up_z,
    output logic               q_valid,
    output lvm_item_t          q_item,
    input  logic               q_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lvm_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg;
    logic [PW-1:0]   rd_reg;
    logic [CW-1:0]   cnt_reg;
    lvm_item_t       item_in;
    logic            push;
    logic            pop;

    assign s_ready = (cnt_reg != CW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        item_in.eye_x  = s_eye_x;
        item_in.eye_y  = s_eye_y;
        item_in.eye_z  = s_eye_z;
        item_in.diff_x = 33'(s_eye_x) - 33'(s_target_x);
        item_in.diff_y = 33'(s_eye_y) - 33'(s_target_y);
        item_in.diff_z = 33'(s_eye_z) - 33'(s_target_z);
        item_in.up_x   = s_world_up_x;
        item_in.up_y   = s_world_up_y;
        item_in.up_z   = s_world_up_z;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/lvm_norm.sv =====
// Shared normaliser: one-bit scaling steps, sum of squares, digit square root
// and three restoring dividers. Depends on lvm_pkg.
module lvm_norm import lvm_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  lvm_norm_req_t req,
    output lvm_norm_rsp_t rsp
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_MAX   = 3'd1;
    localparam logic [2:0] N_SCALE = 3'd2;
    localparam logic [2:0] N_SQ    = 3'd3;
    localparam logic [2:0] N_SQRT  = 3'd4;
    localparam logic [2:0] N_DIVI  = 3'd5;
    localparam logic [2:0] N_DIV   = 3'd6;

    logic [2:0]          st_reg;
    logic [VW-1:0]       m_reg [3];
    logic                neg_reg [3];
    logic [VW-1:0]       mx_reg;
    logic [59:0]         sq_reg;
    logic [61:0]         sum_reg;
    logic [61:0]         s_reg;
    logic [61:0]         r_reg;
    logic [61:0]         bit_reg;
    logic [47:0]         rem_reg [3];
    logic [47:0]         dsh_reg;
    logic [16:0]         q_reg [3];
    logic [4:0]          k_reg;
    logic                done_reg;
    logic                zero_reg;
    logic signed [UW-1:0] o_reg [3];

    logic [VW-1:0]       mx_next;
    logic [29:0]         msel;
    logic [61:0]         sum_next;
    logic [61:0]         t_sq;
    logic                ge [3];
    logic [16:0]         q_next [3];

    always_comb begin
        mx_next = m_reg[0];
        if (m_reg[1] > mx_next) begin
            mx_next = m_reg[1];
        end
        if (m_reg[2] > mx_next) begin
            mx_next = m_reg[2];
        end
        case (k_reg[1:0])
            2'd0:    msel = m_reg[0][29:0];
            2'd1:    msel = m_reg[1][29:0];
            default: msel = m_reg[2][29:0];
        endcase
        sum_next = (k_reg != '0) ? sum_reg + {2'b00, sq_reg} : sum_reg;
        t_sq = r_reg + bit_reg;
        for (int i = 0; i < 3; i++) begin
            ge[i] = (rem_reg[i] >= dsh_reg);
            q_next[i] = {q_reg[i][15:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= N_IDLE;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (st_reg)
                N_IDLE: begin
                    if (req.start) begin
                        m_reg[0]   <= req.v0[VW-1] ? VW'(-req.v0) : VW'(req.v0);
                        m_reg[1]   <= req.v1[VW-1] ? VW'(-req.v1) : VW'(req.v1);
                        m_reg[2]   <= req.v2[VW-1] ? VW'(-req.v2) : VW'(req.v2);
                        neg_reg[0] <= req.v0[VW-1];
                        neg_reg[1] <= req.v1[VW-1];
                        neg_reg[2] <= req.v2[VW-1];
                        st_reg     <= N_MAX;
                    end
                end
                N_MAX: begin
                    if (mx_next == '0) begin
                        done_reg <= 1'b1;
                        zero_reg <= 1'b1;
                        st_reg   <= N_IDLE;
                    end else begin
                        mx_reg <= mx_next;
                        st_reg <= N_SCALE;
                    end
                end
                N_SCALE: begin
                    if (mx_reg >= (VW'(1) << 30)) begin
                        for (int i = 0; i < 3; i++) begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                        mx_reg <= mx_reg >> 1;
                    end else if (mx_reg < (VW'(1) << 29)) begin
                        for (int i = 0; i < 3; i++) begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                        mx_reg <= mx_reg << 1;
                    end else begin
                        k_reg   <= '0;
                        sum_reg <= '0;
                        st_reg  <= N_SQ;
                    end
                end
                N_SQ: begin
                    sq_reg  <= msel * msel;
                    sum_reg <= sum_next;
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == 5'd3) begin
                        s_reg   <= sum_next;
                        r_reg   <= '0;
                        bit_reg <= 62'd1 << 60;
                        st_reg  <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (s_reg >= t_sq) begin
                        s_reg <= s_reg - t_sq;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        st_reg <= N_DIVI;
                    end
                end
                N_DIVI: begin
                    for (int i = 0; i < 3; i++) begin
                        rem_reg[i] <= {2'b00, m_reg[i][29:0], 16'd0} + 48'(r_reg[30:1]);
                        q_reg[i]   <= '0;
                    end
                    dsh_reg <= {1'b0, r_reg[30:0], 16'd0};
                    k_reg   <= 5'd16;
                    st_reg  <= N_DIV;
                end
                N_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (ge[i]) begin
                            rem_reg[i] <= rem_reg[i] - dsh_reg;
                        end
                        q_reg[i] <= q_next[i];
                    end
                    dsh_reg <= dsh_reg >> 1;
                    k_reg   <= k_reg - 1'b1;
                    if (k_reg == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            o_reg[i] <= neg_reg[i] ? -$signed({1'b0, q_next[i]})
                                                   : $signed({1'b0, q_next[i]});
                        end
                        done_reg <= 1'b1;
                        zero_reg <= 1'b0;
                        st_reg   <= N_IDLE;
                    end
                end
                default: begin
                    st_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.zero = zero_reg;
    assign rsp.o0   = o_reg[0];
    assign rsp.o1   = o_reg[1];
    assign rsp.o2   = o_reg[2];

endmodule

// ===== src/lvm_back.sv =====
// Back end: sequences the normaliser and a shared multiply-accumulate for the
// cross and dot products, then sends the four matrix rows. Depends on lvm_pkg.
module lvm_back import lvm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  lvm_item_t          q_item,
    output logic               q_pop,
    output lvm_norm_req_t      norm_req,
    input  lvm_norm_rsp_t      norm_rsp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_word0,
    output logic signed [31:0] m_word1,
    output logic signed [31:0] m_word2,
    output logic signed [31:0] m_word3,
    output logic               m_last_row,
    output logic               m_degenerate
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_N1   = 3'd1;
    localparam logic [2:0] B_C1   = 3'd2;
    localparam logic [2:0] B_N2   = 3'd3;
    localparam logic [2:0] B_C2   = 3'd4;
    localparam logic [2:0] B_DOT  = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    logic [2:0]            st_reg;
    logic signed [31:0]    eye_reg [3];
    logic signed [31:0]    wup_reg [3];
    logic signed [UW-1:0]  fw_reg [3];
    logic signed [UW-1:0]  rt_reg [3];
    logic signed [31:0]    up_reg [3];
    logic signed [31:0]    tr_reg [3];
    logic                  deg_reg;
    logic                  start_reg;
    logic signed [VW-1:0]  nv_reg [3];
    logic [1:0]            comp_reg;
    logic [1:0]            term_reg;
    logic [1:0]            ph_reg;
    logic signed [65:0]    prod_reg;
    logic signed [67:0]    acc_reg;
    logic [1:0]            row_reg;
    logic                  mv_reg;

    logic signed [32:0]    va [3];
    logic signed [32:0]    vb [3];
    logic [1:0]            idx1;
    logic [1:0]            idx2;
    logic signed [32:0]    op_a;
    logic signed [32:0]    op_b;
    logic                  is_cross;
    logic                  sub;
    logic                  last_term;

    assign q_pop = (st_reg == B_IDLE) && q_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            va[i] = 33'(fw_reg[i]);
            vb[i] = 33'(eye_reg[i]);
        end
        case (st_reg)
            B_C1: begin
                for (int i = 0; i < 3; i++) begin
                    va[i] = 33'(wup_reg[i]);
                    vb[i] = 33'(fw_reg[i]);
                end
            end
            B_C2: begin
                for (int i = 0; i < 3; i++) begin
                    va[i] = 33'(fw_reg[i]);
                    vb[i] = 33'(rt_reg[i]);
                end
            end
            B_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    case (comp_reg)
                        2'd0:    va[i] = 33'(rt_reg[i]);
                        2'd1:    va[i] = 33'(up_reg[i]);
                        default: va[i] = 33'(fw_reg[i]);
                    endcase
                end
            end
            default: begin
            end
        endcase
        case (comp_reg)
            2'd0: begin
                idx1 = 2'd1;
                idx2 = 2'd2;
            end
            2'd1: begin
                idx1 = 2'd2;
                idx2 = 2'd0;
            end
            default: begin
                idx1 = 2'd0;
                idx2 = 2'd1;
            end
        endcase
        is_cross = (st_reg == B_C1) || (st_reg == B_C2);
        if (is_cross) begin
            op_a      = (term_reg == 2'd0) ? va[idx1] : va[idx2];
            op_b      = (term_reg == 2'd0) ? vb[idx2] : vb[idx1];
            sub       = (term_reg != 2'd0);
            last_term = (term_reg == 2'd1);
        end else begin
            op_a      = va[term_reg];
            op_b      = vb[term_reg];
            sub       = 1'b0;
            last_term = (term_reg == 2'd2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= B_IDLE;
            start_reg <= 1'b0;
            mv_reg    <= 1'b0;
            deg_reg   <= 1'b0;
            row_reg   <= '0;
        end else begin
            start_reg <= 1'b0;
            case (st_reg)
                B_IDLE: begin
                    acc_reg  <= '0;
                    comp_reg <= '0;
                    term_reg <= '0;
                    ph_reg   <= '0;
                    if (q_valid) begin
                        eye_reg[0] <= q_item.eye_x;
                        eye_reg[1] <= q_item.eye_y;
                        eye_reg[2] <= q_item.eye_z;
                        wup_reg[0] <= q_item.up_x;
                        wup_reg[1] <= q_item.up_y;
                        wup_reg[2] <= q_item.up_z;
                        nv_reg[0]  <= VW'(q_item.diff_x);
                        nv_reg[1]  <= VW'(q_item.diff_y);
                        nv_reg[2]  <= VW'(q_item.diff_z);
                        start_reg  <= 1'b1;
                        st_reg     <= B_N1;
                    end
                end
                B_N1, B_N2: begin
                    if (norm_rsp.done) begin
                        if (norm_rsp.zero) begin
                            deg_reg <= 1'b1;
                            row_reg <= '0;
                            mv_reg  <= 1'b1;
                            st_reg  <= B_OUT;
                        end else if (st_reg == B_N1) begin
                            fw_reg[0] <= norm_rsp.o0;
                            fw_reg[1] <= norm_rsp.o1;
                            fw_reg[2] <= norm_rsp.o2;
                            deg_reg   <= 1'b0;
                            st_reg    <= B_C1;
                        end else begin
                            rt_reg[0] <= norm_rsp.o0;
                            rt_reg[1] <= norm_rsp.o1;
                            rt_reg[2] <= norm_rsp.o2;
                            st_reg    <= B_C2;
                        end
                    end
                end
                B_C1, B_C2, B_DOT: begin
                    case (ph_reg)
                        2'd0: begin
                            prod_reg <= op_a * op_b;
                            ph_reg   <= 2'd1;
                        end
                        2'd1: begin
                            acc_reg <= sub ? acc_reg - 68'(prod_reg)
                                           : acc_reg + 68'(prod_reg);
                            if (last_term) begin
                                ph_reg <= 2'd2;
                            end else begin
                                term_reg <= term_reg + 1'b1;
                                ph_reg   <= 2'd0;
                            end
                        end
                        default: begin
                            case (st_reg)
                                B_C1:    nv_reg[comp_reg] <= acc_reg[VW-1:0];
                                B_C2:    up_reg[comp_reg] <= rnd_sat(acc_reg, 1'b0);
                                default: tr_reg[comp_reg] <= rnd_sat(acc_reg, 1'b1);
                            endcase
                            acc_reg  <= '0;
                            term_reg <= '0;
                            ph_reg   <= 2'd0;
                            if (comp_reg == 2'd2) begin
                                comp_reg <= '0;
                                case (st_reg)
                                    B_C1: begin
                                        start_reg <= 1'b1;
                                        st_reg    <= B_N2;
                                    end
                                    B_C2: begin
                                        st_reg <= B_DOT;
                                    end
                                    default: begin
                                        row_reg <= '0;
                                        mv_reg  <= 1'b1;
                                        st_reg  <= B_OUT;
                                    end
                                endcase
                            end else begin
                                comp_reg <= comp_reg + 1'b1;
                            end
                        end
                    endcase
                end
                B_OUT: begin
                    if (m_ready) begin
                        if (row_reg == 2'd3) begin
                            mv_reg <= 1'b0;
                            st_reg <= B_IDLE;
                        end else begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        m_word0 = '0;
        m_word1 = '0;
        m_word2 = '0;
        m_word3 = '0;
        if (!deg_reg) begin
            if (row_reg == 2'd3) begin
                m_word0 = tr_reg[0];
                m_word1 = tr_reg[1];
                m_word2 = tr_reg[2];
                m_word3 = ONE_Q16;
            end else begin
                m_word0 = 32'(rt_reg[row_reg]);
                m_word1 = up_reg[row_reg];
                m_word2 = 32'(fw_reg[row_reg]);
            end
        end
    end

    assign m_valid      = mv_reg;
    assign m_row_index  = row_reg;
    assign m_last_row   = (row_reg == 2'd3);
    assign m_degenerate = deg_reg;

    assign norm_req.start = start_reg;
    assign norm_req.v0    = nv_reg[0];
    assign norm_req.v1    = nv_reg[1];
    assign norm_req.v2    = nv_reg[2];

    a_valid_only_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> st_reg == B_OUT)
        else $error("result beat outside output phase");
    a_norm_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_rsp.done |-> (st_reg == B_N1 || st_reg == B_N2))
        else $error("normaliser finished while not awaited");
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_word3 == '0 && m_word0 == '0))
        else $error("degenerate row carries data");
    a_row_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_row) |=> m_valid)
        else $error("row sequence cut short");

endmodule

// ===== src/lookat_view_matrix_unit.sv =====
// Look-at view matrix unit, top level. Depends on lvm_pkg, lvm_front, lvm_norm, lvm_back.
// The time from input beat to first row is set by the shared normaliser, run twice (one
// scaling bit per cycle, 31-step square root, 17-step divide). A zero forward vector
// gives its first row once the first run finds it zero, a zero right vector after the
// second run. The back end takes the next item from the queue only once the last row of
// the current one is accepted, and a row waits while m_ready is low. The input queue
// keeps taking beats meanwhile until it is full. Reset (aresetn, synchronous) empties the
// queue and returns all sequencers to idle.
module lookat_view_matrix_unit import lvm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_world_up_x,
    input  logic signed [31:0] s_world_up_y,
    input  logic signed [31:0] s_world_up_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_word0,
    output logic signed [31:0] m_word1,
    output logic signed [31:0] m_word2,
    output logic signed [31:0] m_word3,
    output logic               m_last_row,
    output logic               m_degenerate
);

    logic          q_valid;
    lvm_item_t     q_item;
    logic          q_pop;
    lvm_norm_req_t norm_req;
    lvm_norm_rsp_t norm_rsp;

    lvm_front #(.DEPTH(DEPTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_eye_x      (s_eye_x),
        .s_eye_y      (s_eye_y),
        .s_eye_z      (s_eye_z),
        .s_target_x   (s_target_x),
        .s_target_y   (s_target_y),
        .s_target_z   (s_target_z),
        .s_world_up_x (s_world_up_x),
        .s_world_up_y (s_world_up_y),
        .s_world_up_z (s_world_up_z),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    lvm_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (norm_req),
        .rsp     (norm_rsp)
    );

    lvm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .norm_req     (norm_req),
        .norm_rsp     (norm_rsp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_index  (m_row_index),
        .m_word0      (m_word0),
        .m_word1      (m_word1),
        .m_word2      (m_word2),
        .m_word3      (m_word3),
        .m_last_row   (m_last_row),
        .m_degenerate (m_degenerate)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for lookat_view_matrix_unit: random and directed eye/target/up
// beats, an in-bench fixed-point view-matrix predictor and a row-by-row scoreboard.
// Depends on lvm_pkg and lookat_view_matrix_unit.
`timescale 1ns / 1ps

module tb import lvm_pkg::*; ();

    typedef struct packed {
        logic [8:0][31:0] v;
    } lookat_req_t;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] w0;
        logic signed [31:0] w1;
        logic signed [31:0] w2;
        logic signed [31:0] w3;
        logic               last;
        logic               degen;
    } view_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_f [9] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_row_index;
    logic signed [31:0] m_word0, m_word1, m_word2, m_word3;
    logic m_last_row, m_degenerate;

    lookat_req_t pending_reqs[$];
    view_row_t   expected_rows[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  rx_hold = 0;
    int  hold_len = 0;
    bit  hold_kick = 1'b0;
    bit  hold_seen = 1'b0;
    int  fails = 0;

    lookat_view_matrix_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_eye_x(s_f[0]), .s_eye_y(s_f[1]), .s_eye_z(s_f[2]),
        .s_target_x(s_f[3]), .s_target_y(s_f[4]), .s_target_z(s_f[5]),
        .s_world_up_x(s_f[6]), .s_world_up_y(s_f[7]), .s_world_up_z(s_f[8]),
        .m_valid(m_valid), .m_ready(m_ready), .m_row_index(m_row_index),
        .m_word0(m_word0), .m_word1(m_word1), .m_word2(m_word2), .m_word3(m_word3),
        .m_last_row(m_last_row), .m_degenerate(m_degenerate)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_q16(longint x);
        longint unsigned m;
        m = x < 0 ? -x : x;
        m = (m + 32768) >> 16;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic bit unit_vector(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx, s, len;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            o[i] = longint'(((m[i] << 16) + len / 2) / len);
            if (v[i] < 0) o[i] = -o[i];
        end
        return 1'b1;
    endfunction

    function automatic void predict_view_rows(lookat_req_t q);
        longint eye[3], wup[3], diff[3], rc[3], fw[3], rt[3], up[3], mat[16], d;
        bit ok;
        view_row_t r;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(q.v[i]));
            wup[i] = longint'($signed(q.v[6 + i]));
            diff[i] = eye[i] - longint'($signed(q.v[3 + i]));
        end
        for (int i = 0; i < 16; i++) mat[i] = 0;
        ok = unit_vector(diff, fw);
        if (ok) begin
            rc[0] = wup[1] * fw[2] - wup[2] * fw[1];
            rc[1] = wup[2] * fw[0] - wup[0] * fw[2];
            rc[2] = wup[0] * fw[1] - wup[1] * fw[0];
            ok = unit_vector(rc, rt);
        end
        if (ok) begin
            up[0] = clamp32(round_q16(fw[1] * rt[2] - fw[2] * rt[1]));
            up[1] = clamp32(round_q16(fw[2] * rt[0] - fw[0] * rt[2]));
            up[2] = clamp32(round_q16(fw[0] * rt[1] - fw[1] * rt[0]));
            for (int i = 0; i < 3; i++) begin
                mat[4 * i] = rt[i];
                mat[4 * i + 1] = up[i];
                mat[4 * i + 2] = fw[i];
            end
            d = rt[0] * eye[0] + rt[1] * eye[1] + rt[2] * eye[2];
            mat[12] = clamp32(-round_q16(d));
            d = up[0] * eye[0] + up[1] * eye[1] + up[2] * eye[2];
            mat[13] = clamp32(-round_q16(d));
            d = fw[0] * eye[0] + fw[1] * eye[1] + fw[2] * eye[2];
            mat[14] = clamp32(-round_q16(d));
            mat[15] = longint'(ONE_Q16);
        end
        for (int k = 0; k < 4; k++) begin
            r.row = k[1:0];
            r.w0 = mat[4 * k][31:0];
            r.w1 = mat[4 * k + 1][31:0];
            r.w2 = mat[4 * k + 2][31:0];
            r.w3 = mat[4 * k + 3][31:0];
            r.last = (k == 3);
            r.degen = !ok;
            expected_rows.push_back(r);
        end
    endfunction

    // drive: present the next pending beat, hold until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                lookat_req_t q;
                q = pending_reqs.pop_front();
                predict_view_rows(q);
                for (int i = 0; i < 9; i++) s_f[i] <= q.v[i];
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // count down a receiver hold-off, restarted on each request
    always @(posedge aclk) begin
        if (hold_kick != hold_seen) begin
            rx_hold <= hold_len;
            hold_seen <= hold_kick;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    // monitor: compare each accepted row beat with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected row beat, row_index %0d", m_row_index);
                    fails++;
                end else begin
                    view_row_t e;
                    e = expected_rows.pop_front();
                    check_field("row_index", e.row, m_row_index);
                    check_field("word0", e.w0, m_word0);
                    check_field("word1", e.w1, m_word1);
                    check_field("word2", e.w2, m_word2);
                    check_field("word3", e.w3, m_word3);
                    check_field("last_row", e.last, m_last_row);
                    check_field("degenerate", e.degen, m_degenerate);
                end
            end
            m_ready <= (rx_hold == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic lookat_req_t make_req(logic [31:0] ex, ey, ez, tx, ty, tz,
                                             ux, uy, uz);
        lookat_req_t q;
        q.v[0] = ex; q.v[1] = ey; q.v[2] = ez;
        q.v[3] = tx; q.v[4] = ty; q.v[5] = tz;
        q.v[6] = ux; q.v[7] = uy; q.v[8] = uz;
        return q;
    endfunction

    function automatic logic [31:0] small_q16();
        return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endfunction

    function automatic lookat_req_t random_req();
        lookat_req_t q;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) q.v[i] = kind < 3 ? $urandom() : small_q16();
        if (kind == 8) begin
            for (int i = 0; i < 3; i++) q.v[3 + i] = q.v[i];
        end else if (kind == 9) begin
            // up along the view direction
            for (int i = 0; i < 3; i++) q.v[6 + i] = 32'(q.v[i] - q.v[3 + i]);
        end
        return q;
    endfunction

    task automatic run_phase(int n, int sidle, int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        repeat (n) pending_reqs.push_back(random_req());
        wait (pending_reqs.size() == 0 && !s_valid && expected_rows.size() == 0);
        repeat (250) @(posedge aclk);
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MX = 32'h7fff_ffff;
    localparam logic [31:0] MN = 32'h8000_0000;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
        pending_reqs.push_back(make_req(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE,
                                        0, ONE, 0));
        pending_reqs.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, 0, 3 * ONE));
        pending_reqs.push_back(make_req(MX, MX, MX, MN, MN, MN, 0, ONE, 0));
        pending_reqs.push_back(make_req(MN, MN, MN, MX, MX, MX, MX, MN, MX));
        pending_reqs.push_back(make_req(MN, 0, 0, 0, 0, 0, 0, ONE, 0));
        pending_reqs.push_back(make_req(MN, MN, MN, MN, MN, 0, 0, ONE, 0));
        pending_reqs.push_back(make_req(MX, MX, MX, MX, MX, MX - 1, MN, 0, 0));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(32'hffff_ffff, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(3 * ONE, -32'sd2 * ONE, ONE, -ONE, ONE, 0,
                                        MN, MN, MN));
        pending_reqs.push_back(make_req(MX, 0, MN, 0, MX, 0, MX, MX, MX));
        // long receiver hold-off while the sender keeps offering beats
        hold_len = 3000;
        hold_kick = !hold_kick;
        wait (pending_reqs.size() == 0 && !s_valid && expected_rows.size() == 0);
        run_phase(100, 0, 0);
        run_phase(100, 69, 0);
        run_phase(100, 0, 69);
        hold_len = 2000;
        hold_kick = !hold_kick;
        run_phase(110, 19, 19);
        repeat (300) @(posedge aclk);
        if (fails == 0 && expected_rows.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(12 * 3000000);
        $display("tb: failure");
        $finish;
    end

endmodule
